@@ hw/rtl/fpba_pkg.sv @@
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared codes and types of the fit policy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

    typedef enum logic [1:0] {
        OP_FIRST_FIT = 2'd0,
        OP_BEST_FIT  = 2'd1,
        OP_WORST_FIT = 2'd2,
        OP_RELEASE   = 2'd3
    } fpba_opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_UNKNOWN_ID = 2'd2,
        ST_BAD_SIZE   = 2'd3
    } fpba_status_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_APPLY = 4'b0100,
        S_WRITE = 4'b1000
    } fpba_state_t;

    localparam int unsigned ID_W       = 16;
    localparam int unsigned COUNT_W    = 5;
    localparam int unsigned START_W    = 4;
    localparam int unsigned OCC_W      = 16;

endpackage

`default_nettype wire

@@ hw/rtl/fpba_req_if.sv @@
// ----------------------------------------------------------------------------
// fpba_req_if
// Request channel: opcode, block count and release id with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [4:0]  block_count;
    logic [15:0] release_id;

    modport source (output valid, output opcode, output block_count,
                    output release_id, input ready);
    modport sink   (input valid, input opcode, input block_count,
                    input release_id, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fpba_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fpba_rsp_if
// Response channel: status, id, run and occupancy with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] alloc_id;
    logic [3:0]  start_block;
    logic [4:0]  run_length;
    logic [15:0] occupancy;

    modport source (output valid, output status, output alloc_id,
                    output start_block, output run_length, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input alloc_id,
                    input start_block, input run_length, input occupancy,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fpba_cell.sv @@
// ----------------------------------------------------------------------------
// fpba_cell
// One heap block: its used bit and one allocation table entry. Passes its
// contents to the next cell of the ring on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_cell
    import fpba_pkg::*;
#(
    parameter int unsigned IDX_W = 4,
    parameter int unsigned CNT_W = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift,
    input  wire logic             d_used,
    input  wire logic             d_valid,
    input  wire logic [ID_W-1:0]  d_id,
    input  wire logic [IDX_W-1:0] d_start,
    input  wire logic [CNT_W-1:0] d_len,
    output logic                  q_used,
    output logic                  q_valid,
    output logic [ID_W-1:0]       q_id,
    output logic [IDX_W-1:0]      q_start,
    output logic [CNT_W-1:0]      q_len
);

    logic             used_reg;
    logic             valid_reg;
    logic [ID_W-1:0]  id_reg;
    logic [IDX_W-1:0] start_reg;
    logic [CNT_W-1:0] len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            used_reg  <= d_used;
            valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            id_reg    <= d_id;
            start_reg <= d_start;
            len_reg   <= d_len;
        end
    end

    assign q_used  = used_reg;
    assign q_valid = valid_reg;
    assign q_id    = id_reg;
    assign q_start = start_reg;
    assign q_len   = len_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fpba_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer at the head of the cell ring: scans free runs and table entries
// as they rotate past, then on success rotates once more to apply the
// allocation or release, and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_ctrl
    import fpba_pkg::*;
#(
    parameter int unsigned HEAP_BLOCKS = 16,
    parameter int unsigned IDX_W       = 4,
    parameter int unsigned CNT_W       = 5
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    fpba_req_if.sink                    req,
    fpba_rsp_if.source                  rsp,
    input  wire logic [HEAP_BLOCKS-1:0] occ_map,
    input  wire logic                   head_used,
    input  wire logic                   head_valid,
    input  wire logic [ID_W-1:0]        head_id,
    input  wire logic [IDX_W-1:0]       head_start,
    input  wire logic [CNT_W-1:0]       head_len,
    output logic                        shift,
    output logic                        tail_used,
    output logic                        tail_valid,
    output logic [ID_W-1:0]             tail_id,
    output logic [IDX_W-1:0]            tail_start,
    output logic [CNT_W-1:0]            tail_len
);

    localparam int unsigned CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam int unsigned OCC_N = (HEAP_BLOCKS < OCC_W) ? HEAP_BLOCKS : OCC_W;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(HEAP_BLOCKS - 1);

    fpba_state_t        state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]    rid_reg, rid_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [IDX_W-1:0]   run_start_reg, run_start_next;
    logic [CNT_W-1:0]   run_len_reg, run_len_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   sel_start_reg, sel_start_next;
    logic [CNT_W-1:0]   best_len_reg, best_len_next;
    logic [CNT_W-1:0]   rel_len_reg, rel_len_next;
    logic               slot_found_reg, slot_found_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [ID_W-1:0]    res_id_reg, res_id_next;
    logic [IDX_W-1:0]   res_start_reg, res_start_next;
    logic [CNT_W-1:0]   res_len_reg, res_len_next;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [START_W-1:0] out_start_reg;
    logic [COUNT_W-1:0] out_len_reg;
    logic [OCC_W-1:0]   out_occ_reg;

    logic               is_release;
    logic               last;
    logic               blk_free;
    logic [CNT_W-1:0]   len_plus;
    logic               cand_v;
    logic [CNT_W-1:0]   cand_len;
    logic [IDX_W-1:0]   cand_start;
    logic               take;
    logic               match;
    logic               bad_size;
    logic               ok;
    logic               in_run;
    logic               load;
    logic [ID_W-1:0]    id_inc;
    logic [OCC_W-1:0]   occ16;
    logic [7:0]         start_wide;

    assign is_release = (op_reg == OP_RELEASE);
    assign last       = (step_reg == LAST_STEP);
    assign blk_free   = !head_used;
    assign len_plus   = run_len_reg + 1'b1;
    assign cand_v     = (blk_free && last) || (!blk_free && run_len_reg != '0);
    assign cand_len   = blk_free ? len_plus : run_len_reg;
    assign cand_start = (blk_free && run_len_reg == '0) ? step_reg : run_start_reg;
    assign take = !is_release && cand_v
                  && (CMP_W'(cand_len) >= CMP_W'(count_reg))
                  && (!found_reg
                      || (op_reg == OP_BEST_FIT && cand_len < best_len_reg)
                      || (op_reg == OP_WORST_FIT && cand_len > best_len_reg));
    assign match = is_release && head_valid && head_id == rid_reg && !found_reg;
    assign bad_size = (req.block_count == '0)
                      || (CMP_W'(req.block_count) > CMP_W'(HEAP_BLOCKS));
    assign in_run = (SUM_W'(step_reg) >= SUM_W'(res_start_reg))
                    && (SUM_W'(step_reg) < SUM_W'(res_start_reg) + SUM_W'(res_len_reg));
    assign id_inc = next_id_reg + 1'b1;
    assign load   = (state_reg == S_WRITE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        occ16 = '0;
        for (int i = 0; i < OCC_N; i++)
        begin
            occ16[i] = occ_map[i];
        end
    end

    assign start_wide = 8'(res_start_reg);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        rid_next        = rid_reg;
        step_next       = step_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        found_next      = found_reg;
        sel_start_next  = sel_start_reg;
        best_len_next   = best_len_reg;
        rel_len_next    = rel_len_reg;
        slot_found_next = slot_found_reg;
        slot_next       = slot_reg;
        next_id_next    = next_id_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_start_next  = res_start_reg;
        res_len_next    = res_len_reg;
        ok              = 1'b0;
        shift           = 1'b0;
        tail_used       = head_used;
        tail_valid      = head_valid;
        tail_id         = head_id;
        tail_start      = head_start;
        tail_len        = head_len;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.opcode;
                    count_next      = req.block_count;
                    rid_next        = req.release_id;
                    step_next       = '0;
                    run_len_next    = '0;
                    found_next      = 1'b0;
                    best_len_next   = '0;
                    slot_found_next = 1'b0;
                    if (req.opcode != OP_RELEASE && bad_size)
                    begin
                        res_status_next = ST_BAD_SIZE;
                        res_id_next     = '0;
                        res_start_next  = '0;
                        res_len_next    = '0;
                        state_next      = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                shift        = 1'b1;
                step_next    = last ? '0 : step_reg + 1'b1;
                run_len_next = blk_free ? len_plus : '0;
                if (blk_free && run_len_reg == '0)
                begin
                    run_start_next = step_reg;
                end
                if (take)
                begin
                    found_next     = 1'b1;
                    sel_start_next = cand_start;
                    best_len_next  = cand_len;
                end
                if (match)
                begin
                    found_next     = 1'b1;
                    sel_start_next = head_start;
                    rel_len_next   = head_len;
                    tail_valid     = 1'b0;
                end
                if (!slot_found_reg && !head_valid)
                begin
                    slot_found_next = 1'b1;
                    slot_next       = step_reg;
                end
                if (last)
                begin
                    ok = is_release ? found_next : (found_next && slot_found_next);
                    if (ok)
                    begin
                        res_status_next = ST_OK;
                        res_id_next     = is_release ? '0 : next_id_reg;
                        res_start_next  = sel_start_next;
                        res_len_next    = is_release ? rel_len_next : CNT_W'(count_reg);
                        state_next      = S_APPLY;
                    end
                    else
                    begin
                        res_status_next = is_release ? ST_UNKNOWN_ID : ST_NO_FIT;
                        res_id_next     = '0;
                        res_start_next  = '0;
                        res_len_next    = '0;
                        state_next      = S_WRITE;
                    end
                end
            end
            S_APPLY:
            begin
                shift     = 1'b1;
                step_next = last ? '0 : step_reg + 1'b1;
                if (is_release)
                begin
                    tail_used = head_used & ~in_run;
                end
                else
                begin
                    tail_used = head_used | in_run;
                    if (step_reg == slot_reg)
                    begin
                        tail_valid = 1'b1;
                        tail_id    = next_id_reg;
                        tail_start = res_start_reg;
                        tail_len   = res_len_reg;
                    end
                end
                if (last)
                begin
                    if (!is_release)
                    begin
                        next_id_next = (id_inc == '0) ? ID_W'(1) : id_inc;
                    end
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            run_len_reg    <= '0;
            found_reg      <= 1'b0;
            slot_found_reg <= 1'b0;
            next_id_reg    <= ID_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            run_len_reg    <= run_len_next;
            found_reg      <= found_next;
            slot_found_reg <= slot_found_next;
            next_id_reg    <= next_id_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        count_reg      <= count_next;
        rid_reg        <= rid_next;
        run_start_reg  <= run_start_next;
        sel_start_reg  <= sel_start_next;
        best_len_reg   <= best_len_next;
        rel_len_reg    <= rel_len_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_start_reg  <= res_start_next;
        res_len_reg    <= res_len_next;
        if (load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_start_reg  <= start_wide[START_W-1:0];
            out_len_reg    <= COUNT_W'(res_len_reg);
            out_occ_reg    <= occ16;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.alloc_id    = out_id_reg;
    assign rsp.start_block = out_start_reg;
    assign rsp.run_length  = out_len_reg;
    assign rsp.occupancy   = out_occ_reg;

    a_next_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_id_reg != '0)
        else $error("id counter reached zero");

    a_rise_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WRITE))
        else $error("result shown without a write state");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && res_status_reg != ST_OK)
        |-> (res_id_reg == '0 && res_len_reg == '0 && res_start_reg == '0))
        else $error("failed item carries nonzero fields");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_STEP)
        else $error("ring step out of range");

    a_id_held_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(next_id_reg))
        else $error("id counter moved during scan");

endmodule

`default_nettype wire

@@ hw/rtl/fit_policy_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top
// Block allocator over a heap of HEAP_BLOCKS blocks with first, best and
// worst fit allocation and release by id.
// ----------------------------------------------------------------------------
// Each heap block is a cell holding its used bit and one allocation table
// entry; the cells form a ring that rotates one cell per cycle past the
// controller while it is in its scan or apply state. An item is taken, then
// the ring makes one full turn to find the free run, the free table slot or
// the entry to release, and a second full turn to write the result back. A
// failed search skips the second turn and a bad size skips both; every item
// may then wait for the previous result item to be taken. Occupancy and
// start_block report the low 16 and 4 bits. Only one item is worked on at a
// time; its finished result item can wait in the output register while the
// next item is taken and scanned.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator_top
    import fpba_pkg::*;
#(
    parameter int unsigned HEAP_BLOCKS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fpba_req_if.sink   req,
    fpba_rsp_if.source rsp
);

    localparam int unsigned IDX_W = $clog2(HEAP_BLOCKS);
    localparam int unsigned CNT_W = $clog2(HEAP_BLOCKS + 1);

    logic                              shift;
    logic [HEAP_BLOCKS-1:0]            q_used;
    logic [HEAP_BLOCKS-1:0]            q_valid;
    logic [HEAP_BLOCKS-1:0][ID_W-1:0]  q_id;
    logic [HEAP_BLOCKS-1:0][IDX_W-1:0] q_start;
    logic [HEAP_BLOCKS-1:0][CNT_W-1:0] q_len;
    logic                              tail_used;
    logic                              tail_valid;
    logic [ID_W-1:0]                   tail_id;
    logic [IDX_W-1:0]                  tail_start;
    logic [CNT_W-1:0]                  tail_len;

    for (genvar k = 0; k < HEAP_BLOCKS; k++)
    begin : g_ring
        if (k == HEAP_BLOCKS - 1)
        begin : g_tail
            fpba_cell #(
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .d_used  (tail_used),
                .d_valid (tail_valid),
                .d_id    (tail_id),
                .d_start (tail_start),
                .d_len   (tail_len),
                .q_used  (q_used[k]),
                .q_valid (q_valid[k]),
                .q_id    (q_id[k]),
                .q_start (q_start[k]),
                .q_len   (q_len[k])
            );
        end
        else
        begin : g_body
            fpba_cell #(
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .d_used  (q_used[k+1]),
                .d_valid (q_valid[k+1]),
                .d_id    (q_id[k+1]),
                .d_start (q_start[k+1]),
                .d_len   (q_len[k+1]),
                .q_used  (q_used[k]),
                .q_valid (q_valid[k]),
                .q_id    (q_id[k]),
                .q_start (q_start[k]),
                .q_len   (q_len[k])
            );
        end
    end

    fpba_ctrl #(
        .HEAP_BLOCKS (HEAP_BLOCKS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .occ_map    (q_used),
        .head_used  (q_used[0]),
        .head_valid (q_valid[0]),
        .head_id    (q_id[0]),
        .head_start (q_start[0]),
        .head_len   (q_len[0]),
        .shift      (shift),
        .tail_used  (tail_used),
        .tail_valid (tail_valid),
        .tail_id    (tail_id),
        .tail_start (tail_start),
        .tail_len   (tail_len)
    );

endmodule

`default_nettype wire
